### sv/cbfsm_pkg.sv
// Package for the CAN bus fault status monitor.
// Holds sizes, register indexes, status bit positions and the per-network
// state record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbfsm_pkg;

    localparam int NETWORKS  = 8;
    localparam int NET_W     = 3;
    localparam int WORD_W    = 16;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] LIMIT_RESET    = 16'd1000;
    localparam logic [WORD_W-1:0] BUSOFF_RESET   = 16'd1;
    localparam logic [WORD_W-1:0] SENDLOCK_RESET = 16'd2;
    localparam logic [WORD_W-1:0] REGCHECK_RESET = 16'd4;
    localparam logic [WORD_W-1:0] TIMER_TOP      = 16'hFFFF;

    // status bit positions
    localparam int ST_REGSTUCK  = 0;
    localparam int ST_BUSOFF    = 1;
    localparam int ST_NOCONNECT = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOCONNECT_LIMIT = 2'd0,
        CFG_BUSOFF_MASK     = 2'd1,
        CFG_SENDLOCK_MASK   = 2'd2,
        CFG_REGCHECK_MASK   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] timer;
        logic              running;
        logic [ST_W-1:0]   status;
    } net_state_t;

endpackage : cbfsm_pkg

`default_nettype wire

### sv/cbfsm_tick_if.sv
// Input channel: one tick item per network.
// Depends on cbfsm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cbfsm_tick_if
    import cbfsm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NET_W-1:0]  network;
    logic [WORD_W-1:0] error_word;
    logic              tx_seen;
    logic              rx_seen;

    modport source (output valid, network, error_word, tx_seen, rx_seen, input ready);
    modport sink   (input valid, network, error_word, tx_seen, rx_seen, output ready);
endinterface : cbfsm_tick_if

`default_nettype wire

### sv/cbfsm_status_if.sv
// Output channel: one status item per tick.
// Depends on cbfsm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cbfsm_status_if
    import cbfsm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [NET_W-1:0] network_out;
    logic             reg_stuck;
    logic             bus_off;
    logic             no_connect;
    logic             status_changed;

    modport source (output valid, network_out, reg_stuck, bus_off, no_connect,
                    status_changed, input ready);
    modport sink   (input valid, network_out, reg_stuck, bus_off, no_connect,
                    status_changed, output ready);
endinterface : cbfsm_status_if

`default_nettype wire

### sv/cbfsm_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on cbfsm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface cbfsm_cfg_if
    import cbfsm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : cbfsm_cfg_if

`default_nettype wire

### sv/can_bus_fault_status_monitor_top.sv
// CAN bus fault status monitor, top level.
// Depends on cbfsm_pkg and the cbfsm_tick_if, cbfsm_status_if, cbfsm_cfg_if interfaces.
//
// Usage:
//   tick   : one item per periodic tick of one network (error word, traffic seen).
//   status : one item per tick: reg_stuck, bus_off, no_connect and a changed flag.
//   cfg    : register writes (limit and three error masks), always ready; write
//            only while no tick is in flight.
// The result passes from the update stage registers into the output register.
// Throughput: one tick per cycle while the output is not stalled, repeated ticks
// to the same network included. Per-network state sits in an 8-entry RAM with
// registered read. The tick is read at accept, updated in the update stage and
// written back when it moves on; a tick that follows its own network directly
// takes the just-written entry from a bypass register.
// Reset: registers go to their defaults, every network reads as cleared state
// (per-entry valid bits), no clearing pass is needed.
// Stall: the result waits in the output register; one more tick can sit in the
// update stage, after that tick.ready drops until status.ready returns.
`timescale 1ns / 1ps
`default_nettype none

module can_bus_fault_status_monitor_top
    import cbfsm_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    cbfsm_tick_if.sink     tick,
    cbfsm_status_if.source status,
    cbfsm_cfg_if.sink      cfg
);

    logic [WORD_W-1:0] limit_reg;
    logic [WORD_W-1:0] busoff_mask_reg;
    logic [WORD_W-1:0] sendlock_mask_reg;
    logic [WORD_W-1:0] regcheck_mask_reg;

    net_state_t        mem [NETWORKS];
    net_state_t        rd_data_reg;
    logic [NETWORKS-1:0] net_valid_reg;

    logic              s1_valid_reg;
    logic [NET_W-1:0]  s1_net_reg;
    logic [WORD_W-1:0] s1_err_reg;
    logic              s1_traffic_reg;
    logic              fwd_hit_reg;
    net_state_t        wb_state_reg;

    logic              out_valid_reg;
    logic [NET_W-1:0]  out_net_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic              out_changed_reg;

    logic              tick_acc;
    logic              s1_adv;
    logic              s1_in_range;
    net_state_t        cur_state;
    net_state_t        new_state;
    logic              changed;

    assign cfg.ready  = 1'b1;
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || status.ready);
    assign tick.ready = !s1_valid_reg || s1_adv;
    assign tick_acc   = tick.valid && tick.ready;
    assign s1_in_range = {1'b0, s1_net_reg} < (NET_W + 1)'(NETWORKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg         <= LIMIT_RESET;
            busoff_mask_reg   <= BUSOFF_RESET;
            sendlock_mask_reg <= SENDLOCK_RESET;
            regcheck_mask_reg <= REGCHECK_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_NOCONNECT_LIMIT: limit_reg         <= cfg.data;
                CFG_BUSOFF_MASK:     busoff_mask_reg   <= cfg.data;
                CFG_SENDLOCK_MASK:   sendlock_mask_reg <= cfg.data;
                CFG_REGCHECK_MASK:   regcheck_mask_reg <= cfg.data;
                default:             ;
            endcase
        end
    end

    // state RAM: read at accept, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (tick_acc)
            rd_data_reg <= mem[tick.network];
        if (s1_adv && s1_in_range)
            mem[s1_net_reg] <= new_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1_in_range)
                net_valid_reg[s1_net_reg] <= 1'b1;
            if (tick_acc)
            begin
                s1_valid_reg <= 1'b1;
                // the write at this edge is missed by the RAM read
                fwd_hit_reg  <= s1_adv && s1_in_range && (s1_net_reg == tick.network);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (status.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_net_reg     <= tick.network;
            s1_err_reg     <= tick.error_word;
            s1_traffic_reg <= tick.tx_seen || tick.rx_seen;
        end
        if (s1_adv)
        begin
            wb_state_reg    <= new_state;
            out_net_reg     <= s1_net_reg;
            out_status_reg  <= s1_in_range ? new_state.status : '0;
            out_changed_reg <= s1_in_range && changed;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
            cur_state = wb_state_reg;
        else if (net_valid_reg[s1_net_reg])
            cur_state = rd_data_reg;
        else
            cur_state = '0;
    end

    // tick update, in the order the fault handling requires
    always_comb
    begin
        new_state = cur_state;
        if (((s1_err_reg & (busoff_mask_reg | sendlock_mask_reg)) != '0) &&
            !new_state.running)
        begin
            new_state.running = 1'b1;
            new_state.timer   = '0;
        end
        if (s1_err_reg != '0)
        begin
            new_state.flags = new_state.flags | s1_err_reg;
            if (s1_err_reg == busoff_mask_reg)
                new_state.flags = new_state.flags | sendlock_mask_reg;
        end
        if ((new_state.flags & regcheck_mask_reg) != '0)
            new_state.status[ST_REGSTUCK] = 1'b1;
        if ((new_state.flags & busoff_mask_reg) != '0)
        begin
            if (s1_traffic_reg)
            begin
                new_state.status[ST_BUSOFF] = 1'b0;
                new_state.flags   = new_state.flags & ~busoff_mask_reg;
                new_state.running = 1'b0;
            end
            else
                new_state.status[ST_BUSOFF] = 1'b1;
        end
        if (((new_state.flags & sendlock_mask_reg) != '0) &&
            (!new_state.running || (new_state.timer >= limit_reg)))
        begin
            if (s1_traffic_reg)
            begin
                new_state.status[ST_NOCONNECT] = 1'b0;
                new_state.flags = new_state.flags & ~sendlock_mask_reg;
            end
            else
                new_state.status[ST_NOCONNECT] = 1'b1;
            new_state.running = 1'b0;
        end
        changed = (new_state.status != cur_state.status);
        if (new_state.running && (new_state.timer != TIMER_TOP))
            new_state.timer = new_state.timer + 1'b1;
    end

    assign status.valid          = out_valid_reg;
    assign status.network_out    = out_net_reg;
    assign status.reg_stuck      = out_status_reg[ST_REGSTUCK];
    assign status.bus_off        = out_status_reg[ST_BUSOFF];
    assign status.no_connect     = out_status_reg[ST_NOCONNECT];
    assign status.status_changed = out_changed_reg;

    // input is only held off by a full update stage behind a stalled output
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (s1_valid_reg && out_valid_reg && !status.ready))
        else $error("tick.ready low without a stalled pipeline");

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("bypass flag set with empty update stage");

    a_wb_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_in_range) |=> net_valid_reg[$past(s1_net_reg)])
        else $error("written network not marked valid");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_valid_reg && (out_net_reg == $past(s1_net_reg))))
        else $error("result did not follow update stage");

endmodule : can_bus_fault_status_monitor_top

`default_nettype wire
